@@ rtl/core/pba_pkg.sv @@
`default_nettype none

package pba_pkg;

    localparam int CounterBits = 16;
    localparam int CmpBits     = (CounterBits > 16) ? CounterBits : 16;
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 16;

    localparam logic [CounterBits-1:0] CtrMax = {CounterBits{1'b1}};

    typedef enum logic [4:0] {
        PH_RELEASED  = 5'b00001,
        PH_APPLYING  = 5'b00010,
        PH_APPLIED   = 5'b00100,
        PH_RELEASING = 5'b01000,
        PH_FAULT     = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        FC_NONE        = 2'd0,
        FC_OVERCURRENT = 2'd1,
        FC_TIMEOUT     = 2'd2,
        FC_SENSOR      = 2'd3
    } t_fault;

    typedef enum logic [2:0] {
        BS_RELEASED  = 3'd0,
        BS_APPLYING  = 3'd1,
        BS_APPLIED   = 3'd2,
        BS_RELEASING = 3'd3,
        BS_FAULT     = 3'd4
    } t_bstate;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_SPEED_LIMIT     = 3'd0,
        CFG_CURRENT_LIMIT   = 3'd1,
        CFG_TIMEOUT_LIMIT   = 3'd2,
        CFG_APPLIED_TARGET  = 3'd3,
        CFG_RELEASED_TARGET = 3'd4
    } t_cfg_idx;

    localparam logic [7:0]  RstSpeedLimit     = 8'd5;
    localparam logic [15:0] RstCurrentLimit   = 16'd1800;
    localparam logic [15:0] RstTimeoutLimit   = 16'd50;
    localparam logic [11:0] RstAppliedTarget  = 12'd1000;
    localparam logic [11:0] RstReleasedTarget = 12'd0;

    typedef struct packed {
        logic [7:0]  speed_limit_kph;
        logic [15:0] current_limit_ma;
        logic [15:0] timeout_limit;
        logic [11:0] applied_target;
        logic [11:0] released_target;
    } t_cfg;

    typedef struct packed {
        logic        sensor_valid;
        logic [15:0] motor_current;
        logic [7:0]  vehicle_speed;
        logic        apply_req;
        logic        release_req;
        logic        pedal_pressed;
        logic [11:0] actuator_pos;
    } t_item;

    typedef struct packed {
        t_phase                 phase;
        t_fault                 fault_latch;
        logic [CounterBits-1:0] move_ticks;
    } t_state;

    typedef struct packed {
        logic    drive_forward;
        logic    drive_reverse;
        logic    applying_flag;
        logic    releasing_flag;
        t_bstate brake_state;
        t_fault  fault_code;
    } t_result;

    function automatic t_bstate phase_code(t_phase ph);
        t_bstate code;
        case (ph)
            PH_RELEASED:  code = BS_RELEASED;
            PH_APPLYING:  code = BS_APPLYING;
            PH_APPLIED:   code = BS_APPLIED;
            PH_RELEASING: code = BS_RELEASING;
            default:      code = BS_FAULT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pba_step.sv @@
`default_nettype none

module pba_step (
    input  var pba_pkg::t_cfg    i_cfg,
    input  var pba_pkg::t_state  i_state,
    input  var pba_pkg::t_item   i_item,
    output var pba_pkg::t_state  o_next,
    output var pba_pkg::t_result o_res
);
    import pba_pkg::*;

    logic                   fwd;
    logic                   rev;
    logic                   flt;
    t_fault                 code;
    logic [CounterBits-1:0] ticks_inc;
    logic                   timed_out;

    always_comb begin
        o_next    = i_state;
        fwd       = 1'b0;
        rev       = 1'b0;
        flt       = 1'b0;
        code      = FC_NONE;
        ticks_inc = (i_state.move_ticks == CtrMax) ? i_state.move_ticks
                                                   : i_state.move_ticks + 1'b1;
        timed_out = CmpBits'(ticks_inc) > CmpBits'(i_cfg.timeout_limit);

        if (!i_item.sensor_valid) begin
            if (i_state.phase != PH_FAULT) begin
                flt  = 1'b1;
                code = FC_SENSOR;
            end
        end else if (i_item.motor_current > i_cfg.current_limit_ma &&
                     (i_state.phase == PH_APPLYING || i_state.phase == PH_RELEASING)) begin
            flt  = 1'b1;
            code = FC_OVERCURRENT;
        end else begin
            case (i_state.phase)
                PH_RELEASED: begin
                    o_next.move_ticks = '0;
                    if (i_item.apply_req && i_item.vehicle_speed <= i_cfg.speed_limit_kph) begin
                        o_next.phase = PH_APPLYING;
                    end
                end
                PH_APPLYING: begin
                    fwd = 1'b1;
                    if (i_item.actuator_pos >= i_cfg.applied_target) begin
                        o_next.phase      = PH_APPLIED;
                        o_next.move_ticks = '0;
                    end else if (timed_out) begin
                        flt  = 1'b1;
                        code = FC_TIMEOUT;
                    end else begin
                        o_next.move_ticks = ticks_inc;
                    end
                end
                PH_APPLIED: begin
                    o_next.move_ticks = '0;
                    if (i_item.release_req && i_item.pedal_pressed) begin
                        o_next.phase = PH_RELEASING;
                    end
                end
                PH_RELEASING: begin
                    rev = 1'b1;
                    if (i_item.actuator_pos <= i_cfg.released_target) begin
                        o_next.phase      = PH_RELEASED;
                        o_next.move_ticks = '0;
                    end else if (timed_out) begin
                        flt  = 1'b1;
                        code = FC_TIMEOUT;
                    end else begin
                        o_next.move_ticks = ticks_inc;
                    end
                end
                PH_FAULT: begin
                end
                default: begin
                    flt  = 1'b1;
                    code = FC_SENSOR;
                end
            endcase
        end

        if (flt) begin
            o_next.phase       = PH_FAULT;
            o_next.fault_latch = code;
            o_next.move_ticks  = '0;
        end

        o_res.drive_forward  = fwd;
        o_res.drive_reverse  = rev;
        o_res.applying_flag  = fwd;
        o_res.releasing_flag = rev;
        o_res.brake_state    = phase_code(o_next.phase);
        o_res.fault_code     = o_next.fault_latch;
    end

endmodule

`default_nettype wire

@@ rtl/core/parking_brake_actuator_fsm.sv @@
`default_nettype none

// Parking-brake actuator controller. Each request on the slave stream is one control tick
// and yields exactly one result on the master stream. One tick per clock is sustained while
// the master stream is not stalled; a result passes through the input register, then the
// phase update and result register, whose feedback loop sets the rate. A fault holds
// until reset. Configuration writes are taken at any time on the config channel but
// belong in idle periods; indexes beyond the register list are ignored.
module parking_brake_actuator_fsm (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] sensor_valid, [16:1] motor_current, [24:17] vehicle_speed, [25] apply_req,
    // [26] release_req, [27] pedal_pressed, [39:28] actuator_pos
    input  wire  [39:0]                        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [0] drive_forward, [1] drive_reverse, [2] applying_flag, [3] releasing_flag,
    // [6:4] brake_state, [8:7] fault_code, [15:9] zero
    output logic [15:0]                        m_axis_tdata,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [pba_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input  wire  [pba_pkg::CfgDataBits-1:0]    i_cfg_data
);
    import pba_pkg::*;

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_in_vld;
    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    t_result r_res;
    logic    r_out_vld;
    logic    adv;

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit_kph  <= RstSpeedLimit;
            r_cfg.current_limit_ma <= RstCurrentLimit;
            r_cfg.timeout_limit    <= RstTimeoutLimit;
            r_cfg.applied_target   <= RstAppliedTarget;
            r_cfg.released_target  <= RstReleasedTarget;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPEED_LIMIT:     r_cfg.speed_limit_kph  <= i_cfg_data[7:0];
                CFG_CURRENT_LIMIT:   r_cfg.current_limit_ma <= i_cfg_data[15:0];
                CFG_TIMEOUT_LIMIT:   r_cfg.timeout_limit    <= i_cfg_data[15:0];
                CFG_APPLIED_TARGET:  r_cfg.applied_target   <= i_cfg_data[11:0];
                CFG_RELEASED_TARGET: r_cfg.released_target  <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.sensor_valid  <= s_axis_tdata[0];
            r_item.motor_current <= s_axis_tdata[16:1];
            r_item.vehicle_speed <= s_axis_tdata[24:17];
            r_item.apply_req     <= s_axis_tdata[25];
            r_item.release_req   <= s_axis_tdata[26];
            r_item.pedal_pressed <= s_axis_tdata[27];
            r_item.actuator_pos  <= s_axis_tdata[39:28];
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{phase: PH_RELEASED, fault_latch: FC_NONE, move_ticks: '0};
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    pba_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_item),
        .o_next  (n_state),
        .o_res   (n_res)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_res.fault_code, r_res.brake_state, r_res.releasing_flag,
                            r_res.applying_flag, r_res.drive_reverse, r_res.drive_forward};

`ifndef SYNTH
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_FAULT |=> r_state.phase == PH_FAULT)
        else $error("fault phase left without reset");

    a_fault_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_FAULT |-> r_state.move_ticks == '0)
        else $error("tick counter running in fault");

    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_res.drive_forward && r_res.drive_reverse))
        else $error("motor driven both ways");

    a_code_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_res.brake_state == BS_FAULT) == (r_res.fault_code != FC_NONE)))
        else $error("fault code disagrees with phase");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_axis_tready |=> $stable(r_state))
        else $error("state advanced while result stalled");
`endif

endmodule

`default_nettype wire
